FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds at every clock edge outside reset.
`define ASSERT_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CHECK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: hw/rtl/tga_rle_pkg.sv
// Types and constants shared by the run-length decoder modules.
`default_nettype none
package tga_rle_pkg;

    // Header bytes at or above this value open a run packet
    localparam int unsigned RUN_THRESH = 128;
    // Run length is header minus this bias
    localparam logic [7:0] RUN_BIAS = 8'd127;
    // Widest pixel in bytes
    localparam logic [2:0] BPP_MAX = 3'd4;
    // Bytes per pixel after reset
    localparam logic [2:0] BPP_RESET = 3'd4;
    // Entries in the queue between decode and output
    localparam int unsigned QUEUE_DEPTH = 2;

    // One decoded result
    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic        image_done;
        logic        overflow_error;
    } t_result;

endpackage
`default_nettype wire

FILE: hw/rtl/tga_rle_if.sv
// Stream interfaces for compressed bytes in and decoded pixels out.
`default_nettype none
interface tga_rle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface tga_rle_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic        overflow_error;

    modport source (output valid, output pixel_value, output repeat_count,
                    output image_done, output overflow_error, input ready);
    modport sink   (input valid, input pixel_value, input repeat_count,
                    input image_done, input overflow_error, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tga_rle_decoder_top.sv
// Top level of the run-length pixel decoder: register port and stream channels.
//
// The decoder takes one compressed byte per clock cycle while its input is
// ready and gives at most one pixel result per byte. Every byte is decoded in
// the cycle it is transferred; its result is written into a two-entry queue
// and is offered on the output channel from the next cycle on, once the
// results ahead of it have left. The input keeps taking bytes while the queue
// has a free entry and no register write is in its access cycle, so with the
// output ready the sustained rate is one byte per cycle. Header bytes and the
// leading bytes of a pixel give no result.
// Registers: bytes per pixel at offset 0, pixel count at the next register
// slot; writing either restarts the decoder and drops a partly gathered pixel.
`default_nettype none
module tga_rle_decoder_top
    import tga_rle_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    tga_rle_in_if.sink              i_in,
    tga_rle_out_if.source           o_out,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic [((PIXEL_COUNT_BITS + 1 > 32) ? 4 : 3)-1:0] i_paddr,
    input  wire logic [((PIXEL_COUNT_BITS + 1 > 32) ? 64 : 32)-1:0] i_pwdata,
    output logic [((PIXEL_COUNT_BITS + 1 > 32) ? 64 : 32)-1:0] o_prdata,
    output logic                    o_pready
);

    localparam int REG_W = PIXEL_COUNT_BITS + 1;
    localparam int DW    = (REG_W > 32) ? 64 : 32;
    localparam int AW    = (REG_W > 32) ? 4 : 3;

    logic [2:0]       r_bpp;
    logic [REG_W-1:0] r_pix_cnt;
    logic             cfg_wr;
    logic             cfg_idx;
    logic [2:0]       bpp_eff;
    logic [REG_W-1:0] total_eff;
    logic             queue_full;
    logic             push;
    t_result          result;

    // Register transfers complete in the access phase
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign cfg_idx  = i_paddr[AW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp     <= BPP_RESET;
            r_pix_cnt <= REG_W'(1);
        end else if (cfg_wr) begin
            if (cfg_idx) begin
                r_pix_cnt <= i_pwdata[REG_W-1:0];
            end else begin
                r_bpp <= i_pwdata[2:0];
            end
        end
    end

    assign o_prdata = cfg_idx ? DW'(r_pix_cnt) : DW'(r_bpp);

    // Bring register values into their working range
    assign bpp_eff = (r_bpp == 3'd0) ? 3'd1 : ((r_bpp > BPP_MAX) ? BPP_MAX : r_bpp);

    always_comb begin
        total_eff = r_pix_cnt;
        if (r_pix_cnt == '0) begin
            total_eff = REG_W'(1);
        end else if (r_pix_cnt[REG_W-1] && (r_pix_cnt[REG_W-2:0] != '0)) begin
            total_eff = {1'b1, {(REG_W-1){1'b0}}};
        end
    end

    tga_rle_front #(
        .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (cfg_wr),
        .i_bpp       (bpp_eff),
        .i_total     (total_eff),
        .i_in        (i_in),
        .i_queue_full(queue_full),
        .o_push      (push),
        .o_result    (result)
    );

    tga_rle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_result(result),
        .o_full  (queue_full),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/tga_rle_front.sv
// Byte decoder: packet headers, pixel gathering, pixel counting and clipping.
`default_nettype none
`include "assert_macros.svh"
module tga_rle_front
    import tga_rle_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = 24
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_restart,
    input  wire logic [2:0]                i_bpp,
    input  wire logic [PIXEL_COUNT_BITS:0] i_total,
    tga_rle_in_if.sink                     i_in,
    input  wire logic                      i_queue_full,
    output logic                           o_push,
    output t_result                        o_result
);

    localparam int PW = PIXEL_COUNT_BITS + 1;

    logic                        r_hdr, n_hdr;
    logic                        r_run, n_run;
    logic [7:0]                  r_left, n_left;
    logic [1:0]                  r_pos, n_pos;
    logic [31:0]                 r_gather, n_gather;
    logic [PIXEL_COUNT_BITS-1:0] r_pixels_done, n_pixels_done;

    logic        accept;
    logic [2:0]  pos_inc;
    logic        pix_end;
    logic [31:0] gather_new;
    logic [PW-1:0] img_left;
    logic        run_over;
    logic [7:0]  run_count;
    logic        run_done;
    logic [7:0]  raw_left_dec;
    logic        raw_done;
    logic        raw_over;
    logic [7:0]  count;
    logic        done;
    logic        over;
    logic [7:0]  left_after;

    // Take a byte whenever the queue has room and no register write is under way
    assign i_in.ready = !i_queue_full && !i_restart;
    assign accept     = i_in.valid && !i_queue_full && !i_restart;

    // Gather the byte into its lane
    assign pos_inc    = {1'b0, r_pos} + 3'd1;
    assign pix_end    = (pos_inc >= i_bpp);
    assign gather_new = r_gather | (32'(i_in.data_byte) << {r_pos, 3'b000});

    // Pixels still owed to the image
    assign img_left = i_total - PW'(r_pixels_done);

    // Run packet: clip to the rest of the image
    assign run_over  = (PW'(r_left) > img_left);
    assign run_count = run_over ? img_left[7:0] : r_left;
    assign run_done  = (PW'(run_count) == img_left);

    // Raw packet: one pixel each, flag a packet that outlives the image
    assign raw_left_dec = r_left - 8'd1;
    assign raw_done     = (img_left == PW'(1));
    assign raw_over     = raw_done && (raw_left_dec != 8'd0);

    assign count      = r_run ? run_count : 8'd1;
    assign done       = r_run ? run_done : raw_done;
    assign over       = r_run ? run_over : raw_over;
    assign left_after = r_run ? 8'd0 : raw_left_dec;

    // Push a result for every finished pixel
    assign o_push                  = accept && !r_hdr && pix_end;
    assign o_result.pixel_value    = gather_new;
    assign o_result.repeat_count   = count;
    assign o_result.image_done     = done;
    assign o_result.overflow_error = over;

    // Next decoder state
    always_comb begin
        n_hdr         = r_hdr;
        n_run         = r_run;
        n_left        = r_left;
        n_pos         = r_pos;
        n_gather      = r_gather;
        n_pixels_done = r_pixels_done;
        if (i_restart) begin
            n_hdr         = 1'b1;
            n_run         = 1'b0;
            n_left        = 8'd0;
            n_pos         = 2'd0;
            n_gather      = 32'd0;
            n_pixels_done = '0;
        end else if (accept) begin
            if (r_hdr) begin
                // Open a packet
                n_run    = (32'(i_in.data_byte) >= RUN_THRESH);
                n_left   = n_run ? (i_in.data_byte - RUN_BIAS) : (i_in.data_byte + 8'd1);
                n_hdr    = 1'b0;
                n_pos    = 2'd0;
                n_gather = 32'd0;
            end else if (!pix_end) begin
                n_gather = gather_new;
                n_pos    = r_pos + 2'd1;
            end else begin
                n_pos    = 2'd0;
                n_gather = 32'd0;
                if (done) begin
                    // Image complete: restart for the next one
                    n_hdr         = 1'b1;
                    n_run         = 1'b0;
                    n_left        = 8'd0;
                    n_pixels_done = '0;
                end else begin
                    n_left        = left_after;
                    n_pixels_done = r_pixels_done + PIXEL_COUNT_BITS'(count);
                    n_hdr         = (left_after == 8'd0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr         <= 1'b1;
            r_run         <= 1'b0;
            r_left        <= 8'd0;
            r_pos         <= 2'd0;
            r_gather      <= 32'd0;
            r_pixels_done <= '0;
        end else begin
            r_hdr         <= n_hdr;
            r_run         <= n_run;
            r_left        <= n_left;
            r_pos         <= n_pos;
            r_gather      <= n_gather;
            r_pixels_done <= n_pixels_done;
        end
    end

    `ASSERT_NEVER(a_zero_count, i_clk, i_rst_n,
        o_push && (o_result.repeat_count == 8'd0), "result with zero repeat count")
    `ASSERT_CHECK(a_over_done, i_clk, i_rst_n,
        (o_push && o_result.overflow_error) |-> o_result.image_done, "overflow without image end")
    `ASSERT_CHECK(a_done_restart, i_clk, i_rst_n,
        (o_push && o_result.image_done) |=> (r_hdr && (r_pixels_done == '0)),
        "no restart after image end")

endmodule
`default_nettype wire

FILE: hw/rtl/tga_rle_queue.sv
// Short result queue between the decoder and the output channel.
`default_nettype none
`include "assert_macros.svh"
module tga_rle_queue
    import tga_rle_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_result  i_result,
    output logic          o_full,
    tga_rle_out_if.source o_out
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_result        r_mem [QUEUE_DEPTH];
    logic [AW-1:0]  r_wr, n_wr;
    logic [AW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_count, n_count;
    logic           pop;
    t_result        head;

    assign pop    = o_out.valid && o_out.ready;
    assign o_full = (r_count == CW'(QUEUE_DEPTH));

    // Present the oldest entry
    assign head                 = r_mem[r_rd];
    assign o_out.valid          = (r_count != '0);
    assign o_out.pixel_value    = head.pixel_value;
    assign o_out.repeat_count   = head.repeat_count;
    assign o_out.image_done     = head.image_done;
    assign o_out.overflow_error = head.overflow_error;

    // Advance pointers and occupancy
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (pop) begin
            n_rd = (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store the pushed result
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_result;
        end
    end

    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n,
        r_count > CW'(QUEUE_DEPTH), "queue occupancy out of range")
    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `ASSERT_CHECK(a_count_up, i_clk, i_rst_n,
        (i_push && !pop) |=> (r_count == $past(r_count) + CW'(1)),
        "occupancy did not rise on push")

endmodule
`default_nettype wire

FILE: tb/tga_rle_decoder_top_tb.sv
// Self-checking bench for the TGA run-length decoder: directed table, random packets, predictor.
`default_nettype none
module tga_rle_decoder_top_tb;
    import tga_rle_pkg::*;

    localparam int          PIX_BITS   = 24;
    localparam logic [25:0] PIX_CAP    = 26'd1 << PIX_BITS;
    localparam logic [2:0]  ADDR_BPP   = 3'd0;
    localparam logic [2:0]  ADDR_COUNT = 3'd4;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          RAND_BYTES = 1300;

    typedef enum logic [1:0] {ROW_BYTE, ROW_BPP, ROW_COUNT} t_row_kind;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_RARE, RX_BURSTY} t_rx_mode;

    typedef struct {
        t_row_kind   kind;
        logic [31:0] value;
        bit          typed;
        t_result     res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tga_rle_in_if  in_ch();
    tga_rle_out_if out_ch();

    tga_rle_decoder_top #(.PIXEL_COUNT_BITS(PIX_BITS)) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Decoder image held by the bench
    logic [2:0]  cfg_bpp;
    logic [24:0] cfg_count;
    bit          await_header;
    bit          pkt_run;
    logic [7:0]  pkt_left;
    logic [1:0]  gather_pos;
    logic [31:0] gather;
    logic [25:0] done_px;

    t_result     pending_px[$];
    t_stim_row   rows[$];
    t_result     exp_px;
    int          fail_count;
    int          burst_left;
    int          idle_cycles;
    t_rx_mode    rx_mode;
    logic [7:0]  rx_tick;

    function automatic void restart_decode();
        await_header = 1'b1;
        pkt_run      = 1'b0;
        pkt_left     = '0;
        gather_pos   = '0;
        gather       = '0;
        done_px      = '0;
    endfunction

    function automatic logic [2:0] pix_bytes();
        if (cfg_bpp == 3'd0)
            return 3'd1;
        if (cfg_bpp > BPP_MAX)
            return BPP_MAX;
        return cfg_bpp;
    endfunction

    function automatic logic [25:0] image_pixels();
        if (cfg_count == '0)
            return 26'd1;
        if ({1'b0, cfg_count} > PIX_CAP)
            return PIX_CAP;
        return {1'b0, cfg_count};
    endfunction

    // Advance the decoder by one byte; return 1 when a pixel result comes out
    function automatic bit decode_byte(input logic [7:0] b, output t_result r);
        logic [25:0] room;
        logic [7:0]  cnt;
        bit          ovf;
        bit          fin;
        r = '0;
        ovf = 1'b0;
        if (await_header) begin
            pkt_run      = (b >= 8'(RUN_THRESH));
            pkt_left     = pkt_run ? b - RUN_BIAS : b + 8'd1;
            await_header = 1'b0;
            gather_pos   = '0;
            gather       = '0;
            return 1'b0;
        end
        gather     = gather | (32'(b) << (8 * gather_pos));
        gather_pos = gather_pos + 2'd1;
        if (gather_pos != 2'd0 && {1'b0, gather_pos} < pix_bytes())
            return 1'b0;

        room = image_pixels() - done_px;
        if (pkt_run) begin
            cnt = pkt_left;
            if ({18'd0, pkt_left} > room) begin
                cnt = room[7:0];
                ovf = 1'b1;
            end
            pkt_left = '0;
        end else begin
            cnt      = 8'd1;
            pkt_left = pkt_left - 8'd1;
            if (room == 26'd1 && pkt_left != '0)
                ovf = 1'b1;
        end
        done_px = done_px + {18'd0, cnt};
        fin     = (done_px >= image_pixels());

        r.pixel_value    = gather;
        r.repeat_count   = cnt;
        r.image_done     = fin;
        r.overflow_error = ovf;

        gather_pos = '0;
        gather     = '0;
        if (fin)
            restart_decode();
        else if (pkt_left == '0)
            await_header = 1'b1;
        return 1'b1;
    endfunction

    function automatic t_stim_row cfg_row(input t_row_kind k, input logic [31:0] v);
        t_stim_row r;
        r.kind  = k;
        r.value = v;
        r.typed = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    function automatic t_stim_row byte_row(input logic [7:0] b);
        return cfg_row(ROW_BYTE, {24'd0, b});
    endfunction

    function automatic t_stim_row pix_row(input logic [7:0] b, input logic [31:0] pix,
                                          input logic [7:0] cnt, input bit fin, input bit ovf);
        t_stim_row r;
        r = cfg_row(ROW_BYTE, {24'd0, b});
        r.typed              = 1'b1;
        r.res.pixel_value    = pix;
        r.res.repeat_count   = cnt;
        r.res.image_done     = fin;
        r.res.overflow_error = ovf;
        return r;
    endfunction

    function automatic logic [31:0] rand_count();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return 32'd0;
        if (pick == 1)
            return 32'h01FF_FFFF;
        // Upper bits beyond the register are dropped
        if (pick == 2)
            return 32'hFFFF_FFFF;
        return 32'($urandom_range(1, 400));
    endfunction

    // Offer one byte in bursts with random gaps; predict at the transfer edge
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_result tres);
        t_result r;
        bit      got;
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left      = burst_left - 1;
        in_ch.valid     = 1'b1;
        in_ch.data_byte = b;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        got = decode_byte(b, r);
        if (typed) begin
            if (!got) begin
                $error("result missing for byte %0h", b);
                fail_count++;
            end
            pending_px.push_back(tres);
        end else if (got) begin
            pending_px.push_back(r);
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // Register write once every expected result has drained
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] v);
        logic [31:0] rd_exp;
        while (pending_px.size() != 0)
            @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_BPP)
            cfg_bpp = v[2:0];
        else
            cfg_count = v[24:0];
        restart_decode();
        @(negedge i_clk);
        rd_exp = (addr == ADDR_BPP) ? {29'd0, v[2:0]} : {7'd0, v[24:0]};
        if (prdata !== rd_exp) begin
            $error("prdata mismatch: expected %0h, actual %0h", rd_exp, prdata);
            fail_count++;
        end
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Compare each output transfer with the oldest expected result
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_px.size() == 0) begin
                $error("result not expected: pixel_value %0h", out_ch.pixel_value);
                fail_count++;
            end else begin
                exp_px = pending_px.pop_front();
                check_field("pixel_value", exp_px.pixel_value, out_ch.pixel_value);
                check_field("repeat_count", {24'd0, exp_px.repeat_count},
                            {24'd0, out_ch.repeat_count});
                check_field("image_done", {31'd0, exp_px.image_done},
                            {31'd0, out_ch.image_done});
                check_field("overflow_error", {31'd0, exp_px.overflow_error},
                            {31'd0, out_ch.overflow_error});
            end
        end
    end

    // Stall the receiver on a pattern of its own
    always @(negedge i_clk) begin
        rx_tick = rx_tick + 8'd1;
        if (rx_tick == 8'd0)
            rx_mode = t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN: out_ch.ready = 1'b1;
            RX_COIN: out_ch.ready = 1'($urandom_range(0, 1));
            RX_RARE: out_ch.ready = ($urandom_range(0, 3) == 0);
            default: out_ch.ready = rx_tick[3];
        endcase
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("no transfer for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        out_ch.ready    = 1'b1;
        rx_mode         = RX_OPEN;
        rx_tick         = '0;
        fail_count      = 0;
        burst_left      = 0;
        idle_cycles     = 0;
        cfg_bpp         = BPP_RESET;
        cfg_count       = 25'd1;
        restart_decode();

        // After reset: four bytes per pixel, one pixel per image
        rows.push_back(byte_row(8'h00));
        rows.push_back(byte_row(8'h11));
        rows.push_back(byte_row(8'h22));
        rows.push_back(byte_row(8'h33));
        rows.push_back(pix_row(8'h44, 32'h4433_2211, 8'd1, 1'b1, 1'b0));
        // Gray image of ten pixels: run, raw, then a clipped run
        rows.push_back(cfg_row(ROW_BPP, 32'd1));
        rows.push_back(cfg_row(ROW_COUNT, 32'd10));
        rows.push_back(byte_row(8'h83));
        rows.push_back(pix_row(8'hAB, 32'h0000_00AB, 8'd4, 1'b0, 1'b0));
        rows.push_back(byte_row(8'h01));
        rows.push_back(pix_row(8'h10, 32'h0000_0010, 8'd1, 1'b0, 1'b0));
        rows.push_back(pix_row(8'h20, 32'h0000_0020, 8'd1, 1'b0, 1'b0));
        rows.push_back(byte_row(8'hFF));
        rows.push_back(pix_row(8'h55, 32'h0000_0055, 8'd4, 1'b1, 1'b1));
        // Raw packet running past a two-pixel image
        rows.push_back(cfg_row(ROW_COUNT, 32'd2));
        rows.push_back(byte_row(8'h04));
        rows.push_back(pix_row(8'h01, 32'h0000_0001, 8'd1, 1'b0, 1'b0));
        rows.push_back(pix_row(8'h02, 32'h0000_0002, 8'd1, 1'b1, 1'b1));
        rows.push_back(byte_row(8'h80));
        rows.push_back(pix_row(8'h77, 32'h0000_0077, 8'd1, 1'b0, 1'b0));
        rows.push_back(byte_row(8'h00));
        rows.push_back(pix_row(8'h66, 32'h0000_0066, 8'd1, 1'b1, 1'b0));
        // Bytes per pixel of zero acts as one
        rows.push_back(cfg_row(ROW_BPP, 32'd0));
        rows.push_back(byte_row(8'h80));
        rows.push_back(byte_row(8'h9C));
        // Bytes per pixel of seven acts as four, pixel count of zero as one
        rows.push_back(cfg_row(ROW_BPP, 32'd7));
        rows.push_back(cfg_row(ROW_COUNT, 32'd0));
        rows.push_back(byte_row(8'h80));
        rows.push_back(byte_row(8'hA1));
        rows.push_back(byte_row(8'hA2));
        rows.push_back(byte_row(8'hA3));
        rows.push_back(pix_row(8'hA4, 32'hA4A3_A2A1, 8'd1, 1'b1, 1'b0));
        // Three bytes per pixel, count above the cap, longest raw packet
        rows.push_back(cfg_row(ROW_BPP, 32'd3));
        rows.push_back(cfg_row(ROW_COUNT, 32'h01FF_FFFF));
        rows.push_back(byte_row(8'h7F));
        for (int k = 0; k < 6; k++)
            rows.push_back(byte_row(8'(8'hC0 + k)));
        // A register write drops a partly gathered pixel
        rows.push_back(byte_row(8'hE1));
        rows.push_back(byte_row(8'hE2));
        rows.push_back(cfg_row(ROW_COUNT, 32'd5));
        rows.push_back(byte_row(8'h81));
        rows.push_back(byte_row(8'h01));
        rows.push_back(byte_row(8'h02));
        rows.push_back(byte_row(8'h03));
        rows.push_back(byte_row(8'h00));
        rows.push_back(byte_row(8'h04));
        rows.push_back(byte_row(8'h05));
        rows.push_back(byte_row(8'h06));
        // Longest run clipped to a five-pixel image
        rows.push_back(cfg_row(ROW_BPP, 32'd4));
        rows.push_back(byte_row(8'hFF));
        rows.push_back(byte_row(8'hDE));
        rows.push_back(byte_row(8'hAD));
        rows.push_back(byte_row(8'hBE));
        rows.push_back(pix_row(8'hEF, 32'hEFBE_ADDE, 8'd5, 1'b1, 1'b1));

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        foreach (rows[i]) begin
            case (rows[i].kind)
                ROW_BPP:   write_reg(ADDR_BPP, rows[i].value);
                ROW_COUNT: write_reg(ADDR_COUNT, rows[i].value);
                default:   send_byte(rows[i].value[7:0], rows[i].typed, rows[i].res);
            endcase
        end

        // Random stream with occasional register writes
        write_reg(ADDR_COUNT, 32'd300);
        for (int n = 0; n < RAND_BYTES; n++) begin
            if ($urandom_range(0, 199) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    write_reg(ADDR_BPP, 32'($urandom_range(0, 7)));
                else
                    write_reg(ADDR_COUNT, rand_count());
            end
            send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end

        // Drain and report
        while (pending_px.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
